@@ rtl/vertex_transform_4x4_core_macros.svh @@
// assertion macros shared by the checker
`ifndef VERTEX_TRANSFORM_4X4_CORE_MACROS_SVH
`define VERTEX_TRANSFORM_4X4_CORE_MACROS_SVH

// clocked assertion, disabled while reset is held
`define VT4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a stalled result beat keeps the given signal
`define VT4_ASSERT_HOLD(lbl, sig, msg) \
  `VT4_ASSERT(lbl, out_valid && out_stall |=> $stable(sig), msg)

`endif

@@ rtl/vt4_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package vt4_pkg;

  // default widths
  localparam int COEF_WIDTH_DEF = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field and register widths
  localparam int FIELD_WIDTH   = 32;
  localparam int ROW_WIDTH     = 64;
  localparam int SLOT_WIDTH    = 16;
  localparam int CFG_IDX_WIDTH = 3;

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW_0 = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW_1 = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW_2 = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW_3 = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MODE  = 3'd4;

  // identity matrix at reset
  localparam logic [ROW_WIDTH-1:0] ROW_RST_0 = 64'h0000_0000_0000_1000;
  localparam logic [ROW_WIDTH-1:0] ROW_RST_1 = 64'h0000_0000_1000_0000;
  localparam logic [ROW_WIDTH-1:0] ROW_RST_2 = 64'h0000_1000_0000_0000;
  localparam logic [ROW_WIDTH-1:0] ROW_RST_3 = 64'h1000_0000_0000_0000;

  // per-stage load enables of the datapath
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } stage_en_t;

endpackage

`default_nettype wire

@@ rtl/vt4_dot4.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vt4_dot4 #(
  parameter int COEF_WIDTH = vt4_pkg::COEF_WIDTH_DEF,
  parameter int DATA_WIDTH = vt4_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                         clk,
  input  wire vt4_pkg::stage_en_t                           en,
  input  wire logic signed [COEF_WIDTH-1:0]                 coef [4],
  input  wire logic signed [((DATA_WIDTH < 32) ? DATA_WIDTH : 32)-1:0] data [4],
  output logic signed [vt4_pkg::FIELD_WIDTH-1:0]            res,
  output logic                                              sat
);

  localparam int IW   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int PW   = COEF_WIDTH + IW;
  localparam int QW   = PW + 1;
  localparam int RW   = PW + 3;
  localparam int FRAC = COEF_WIDTH - 4;
  localparam int EW   = ((RW > DATA_WIDTH) ? RW : DATA_WIDTH) + 1;

  localparam logic signed [RW-1:0] RND    = RW'(64'sd1 <<< (FRAC - 1));
  localparam logic signed [EW-1:0] HI_LIM = EW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] LO_LIM = EW'(-(64'sd1 <<< (DATA_WIDTH - 1)));

  logic signed [PW-1:0] prod_r [4];
  logic signed [PW-1:0] prod_nxt [4];
  logic signed [QW-1:0] pair_r [2];
  logic signed [QW-1:0] pair_nxt [2];
  logic signed [RW-1:0] sum_r;
  logic signed [RW-1:0] sum_nxt;
  logic signed [RW-1:0] rnd_val;
  logic signed [EW-1:0] ext_val;
  logic signed [EW-1:0] clamp_val;
  logic signed [63:0]   wide_val;
  logic signed [vt4_pkg::FIELD_WIDTH-1:0] res_nxt;
  logic                 sat_nxt;
  logic signed [vt4_pkg::FIELD_WIDTH-1:0] res_r;
  logic                 sat_r;

  // stage 1: four products
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_nxt[k] = PW'(coef[k]) * PW'(data[k]);
    end
  end

  // stage 2: pair sums
  always_comb begin
    pair_nxt[0] = QW'(prod_r[0]) + QW'(prod_r[1]);
    pair_nxt[1] = QW'(prod_r[2]) + QW'(prod_r[3]);
  end

  // stage 3: full sum plus half an lsb
  assign sum_nxt = RW'(pair_r[0]) + RW'(pair_r[1]) + RND;

  // stage 4: drop fraction bits, clamp to the data range
  always_comb begin
    rnd_val = sum_r >>> FRAC;
    ext_val = EW'(rnd_val);
    sat_nxt = 1'b0;
    if (ext_val > HI_LIM) begin
      clamp_val = HI_LIM;
      sat_nxt   = 1'b1;
    end else if (ext_val < LO_LIM) begin
      clamp_val = LO_LIM;
      sat_nxt   = 1'b1;
    end else begin
      clamp_val = ext_val;
    end
    wide_val = 64'(clamp_val);
    res_nxt  = wide_val[vt4_pkg::FIELD_WIDTH-1:0];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en.en1) begin
      prod_r <= prod_nxt;
    end
    if (en.en2) begin
      pair_r <= pair_nxt;
    end
    if (en.en3) begin
      sum_r <= sum_nxt;
    end
    if (en.en4) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule

`default_nettype wire

@@ rtl/vertex_transform_4x4_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// four register stages: products, pair sums, rounded sum, clamped output
// a result is offered after its input beat has passed the product, pair-sum, sum and output registers
// one beat per cycle sustained while out_stall is low; each stage holds only while the stage after it is full
// and stalled, so bubbles close up under a stalled output
// synchronous active-low reset empties the pipeline and loads the identity matrix, mode 0

module vertex_transform_4x4_core #(
  parameter int COEF_WIDTH = vt4_pkg::COEF_WIDTH_DEF,
  parameter int DATA_WIDTH = vt4_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // configuration
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [vt4_pkg::CFG_IDX_WIDTH-1:0]      cfg_index,
  input  wire logic [vt4_pkg::ROW_WIDTH-1:0]          cfg_data,
  // input vectors
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [vt4_pkg::FIELD_WIDTH-1:0] in_x,
  input  wire logic signed [vt4_pkg::FIELD_WIDTH-1:0] in_y,
  input  wire logic signed [vt4_pkg::FIELD_WIDTH-1:0] in_z,
  input  wire logic signed [vt4_pkg::FIELD_WIDTH-1:0] in_w,
  // transformed vectors
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [vt4_pkg::FIELD_WIDTH-1:0]      out_x,
  output logic signed [vt4_pkg::FIELD_WIDTH-1:0]      out_y,
  output logic signed [vt4_pkg::FIELD_WIDTH-1:0]      out_z,
  output logic signed [vt4_pkg::FIELD_WIDTH-1:0]      out_w,
  output logic                                        out_saturated
);

  localparam int IW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  logic [vt4_pkg::ROW_WIDTH-1:0] rows_r [4];
  logic                          mode_r;

  logic v1_r, v2_r, v3_r, v4_r;
  vt4_pkg::stage_en_t en;

  logic signed [COEF_WIDTH-1:0] coef [4][4];
  logic signed [IW-1:0]         data [4];
  logic signed [vt4_pkg::FIELD_WIDTH-1:0] res [4];
  logic [3:0]                   sat;
  logic [vt4_pkg::SLOT_WIDTH-1:0] slot;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r[0] <= vt4_pkg::ROW_RST_0;
      rows_r[1] <= vt4_pkg::ROW_RST_1;
      rows_r[2] <= vt4_pkg::ROW_RST_2;
      rows_r[3] <= vt4_pkg::ROW_RST_3;
      mode_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vt4_pkg::REG_ROW_0: rows_r[0] <= cfg_data;
        vt4_pkg::REG_ROW_1: rows_r[1] <= cfg_data;
        vt4_pkg::REG_ROW_2: rows_r[2] <= cfg_data;
        vt4_pkg::REG_ROW_3: rows_r[3] <= cfg_data;
        vt4_pkg::REG_MODE:  mode_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // coefficient selection: row form uses the transpose
  always_comb begin
    slot = '0;
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        if (mode_r) begin
          slot = rows_r[k][vt4_pkg::SLOT_WIDTH*i +: vt4_pkg::SLOT_WIDTH];
        end else begin
          slot = rows_r[i][vt4_pkg::SLOT_WIDTH*k +: vt4_pkg::SLOT_WIDTH];
        end
        coef[i][k] = slot[COEF_WIDTH-1:0];
      end
    end
  end

  // input components, low bits taken as signed
  assign data[0] = in_x[IW-1:0];
  assign data[1] = in_y[IW-1:0];
  assign data[2] = in_z[IW-1:0];
  assign data[3] = in_w[IW-1:0];

  // stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en.en4 = !v4_r || !out_stall;
    en.en3 = !v3_r || en.en4;
    en.en2 = !v2_r || en.en3;
    en.en1 = !v1_r || en.en2;
  end

  assign in_stall = !en.en1;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.en1) begin
        v1_r <= in_valid;
      end
      if (en.en2) begin
        v2_r <= v1_r;
      end
      if (en.en3) begin
        v3_r <= v2_r;
      end
      if (en.en4) begin
        v4_r <= v3_r;
      end
    end
  end

  // one dot-product pipeline per output component
  for (genvar i = 0; i < 4; i++) begin : g_dot
    vt4_dot4 #(
      .COEF_WIDTH (COEF_WIDTH),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_dot (
      .clk  (clk),
      .en   (en),
      .coef (coef[i]),
      .data (data),
      .res  (res[i]),
      .sat  (sat[i])
    );
  end

  // result beat
  assign out_valid     = v4_r;
  assign out_x         = res[0];
  assign out_y         = res[1];
  assign out_z         = res[2];
  assign out_w         = res[3];
  assign out_saturated = |sat;

endmodule

`default_nettype wire

@@ rtl/vt4_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_transform_4x4_core_macros.svh"

module vt4_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_x,
  input wire logic        out_saturated
);

  // input only backs up when every stage is full behind a stalled result
  `VT4_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with room")

  // an accepted beat reaches the output when the output does not stall while it passes through the pipeline
  `VT4_ASSERT(a_latency, (in_valid && !in_stall) ##1 !out_stall [*3] |=> out_valid, "result lost")

  // the register port never pushes back
  `VT4_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "configuration write refused")

  // a stalled result keeps its payload
  `VT4_ASSERT_HOLD(a_hold_x, out_x, "stalled result changed")

  // a stalled result keeps its clamp flag
  `VT4_ASSERT_HOLD(a_hold_sat, out_saturated, "stalled flag changed")

endmodule

bind vertex_transform_4x4_core vt4_checker u_vt4_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_x         (out_x),
  .out_saturated (out_saturated)
);

`default_nettype wire
